>>> hdl/iplr_pkg.sv
// Shared constants and types of the interval pool bound relaxation block.
// No dependencies; iplr_back and the top level refer to it by scoped names.
`default_nettype none
package iplr_pkg;

  localparam int unsigned FracBits = 16;

  localparam logic PoolMax = 1'b0;
  localparam logic PoolAvg = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_MUL   = 5'b01000,
    ST_DONE  = 5'b10000
  } back_state_e;

  typedef enum logic [1:0] {
    JOB_LOW,
    JOB_UPP,
    JOB_SLOPE_AVG,
    JOB_SLOPE_MAX
  } div_job_e;

endpackage
`default_nettype wire

>>> hdl/iplr_in_if.sv
// Element input channel: valid/ready handshake with one window element.
// No dependencies.
`default_nettype none
interface iplr_in_if #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned INDEX_BITS = 20
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] lower;
  logic [VALUE_BITS-1:0] upper;
  logic [INDEX_BITS-1:0] var_index;
  logic                  last;

  modport source (output valid, lower, upper, var_index, last, input ready);
  modport sink (input valid, lower, upper, var_index, last, output ready);
endinterface
`default_nettype wire

>>> hdl/iplr_out_if.sv
// Result channel: valid/ready handshake with one relaxed pooling output.
// No dependencies.
`default_nettype none
interface iplr_out_if #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned INDEX_BITS = 20
);
  logic                  valid;
  logic                  ready;
  logic                  exact_copy;
  logic [INDEX_BITS-1:0] upper_var;
  logic [INDEX_BITS-1:0] lower_var;
  logic [VALUE_BITS-1:0] slope;
  logic [VALUE_BITS-1:0] offset;
  logic [VALUE_BITS-1:0] lower_bound;
  logic [VALUE_BITS-1:0] upper_bound;
  logic                  empty_window;

  modport source (output valid, exact_copy, upper_var, lower_var, slope, offset,
                  lower_bound, upper_bound, empty_window, input ready);
  modport sink (input valid, exact_copy, upper_var, lower_var, slope, offset,
                lower_bound, upper_bound, empty_window, output ready);
endinterface
`default_nettype wire

>>> hdl/iplr_cfg_if.sv
// Configuration write channel carrying the pool_kind register.
// No dependencies.
`default_nettype none
interface iplr_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

>>> hdl/iplr_front.sv
// Front end: folds window elements into running maxima and sums and pushes
// a window snapshot into the queue on the last element. Uses iplr_in_if.
`default_nettype none
module iplr_front #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned INDEX_BITS = 20,
  parameter int unsigned MAX_WINDOW = 16,
  localparam int unsigned CW = $clog2(MAX_WINDOW + 1),
  localparam int unsigned SW = VALUE_BITS + CW,
  localparam int unsigned SNAP_W = 2 + CW + 4 * VALUE_BITS + 2 * INDEX_BITS + 2 * SW
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  iplr_in_if.sink                in_i,
  input  wire logic              pool_kind_i,
  input  wire logic              full_i,
  output logic                   push_o,
  output logic [SNAP_W-1:0]      snap_o
);

  typedef struct packed {
    logic                  kind;
    logic [CW-1:0]         cnt;
    logic [VALUE_BITS-1:0] tu;
    logic [VALUE_BITS-1:0] tul;
    logic [INDEX_BITS-1:0] tuv;
    logic [VALUE_BITS-1:0] su;
    logic                  sv;
    logic [VALUE_BITS-1:0] tl;
    logic [INDEX_BITS-1:0] tmv;
    logic [SW-1:0]         sl;
    logic [SW-1:0]         sus;
  } snap_t;

  snap_t                       win_q, win_d, nxt;
  logic signed [VALUE_BITS:0]  tms_q, tms_d, nxt_tms, mid_s;
  logic signed [VALUE_BITS-1:0] lo_s, up_s;
  logic                        first, accept;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign lo_s       = in_i.lower;
  assign up_s       = in_i.upper;
  assign mid_s      = {lo_s[VALUE_BITS-1], lo_s} + {up_s[VALUE_BITS-1], up_s};
  assign first      = (win_q.cnt == '0);

  always_comb begin
    nxt     = win_q;
    nxt_tms = tms_q;
    if (win_q.cnt < CW'(MAX_WINDOW)) begin
      if (first || (up_s > $signed(win_q.tu))) begin
        if (!first) begin
          nxt.su = win_q.tu;
          nxt.sv = 1'b1;
        end
        nxt.tu  = in_i.upper;
        nxt.tuv = in_i.var_index;
        nxt.tul = in_i.lower;
      end else if (!win_q.sv || (up_s > $signed(win_q.su))) begin
        nxt.su = in_i.upper;
        nxt.sv = 1'b1;
      end
      if (first || (lo_s > $signed(win_q.tl))) begin
        nxt.tl = in_i.lower;
      end
      if (first || (mid_s > tms_q)) begin
        nxt_tms = mid_s;
        nxt.tmv = in_i.var_index;
      end
      nxt.sl  = win_q.sl + {{(SW - VALUE_BITS){lo_s[VALUE_BITS-1]}}, in_i.lower};
      nxt.sus = win_q.sus + {{(SW - VALUE_BITS){up_s[VALUE_BITS-1]}}, in_i.upper};
      nxt.cnt = win_q.cnt + 1'b1;
    end
    nxt.kind = pool_kind_i;
  end

  always_comb begin
    win_d = win_q;
    tms_d = tms_q;
    if (accept) begin
      win_d = nxt;
      tms_d = nxt_tms;
      if (in_i.last) begin
        // close the window: clear counters, sums restart from zero
        win_d.cnt = '0;
        win_d.sv  = 1'b0;
        win_d.sl  = '0;
        win_d.sus = '0;
      end
    end
  end

  assign push_o = accept && in_i.last;
  assign snap_o = nxt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      tms_q <= '0;
    end else begin
      win_q <= win_d;
      tms_q <= tms_d;
    end
  end

endmodule
`default_nettype wire

>>> hdl/iplr_queue.sv
// Two-entry queue of window snapshots between front and back end.
// No dependencies.
`default_nettype none
module iplr_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  full_o,
  output logic                  empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule
`default_nettype wire

>>> hdl/iplr_back.sv
// Back end: takes window snapshots, runs the bit-serial divider and
// shift-add multiplier, holds the result in an output register.
// Uses iplr_pkg and iplr_out_if.
`default_nettype none
module iplr_back #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned INDEX_BITS = 20,
  parameter int unsigned MAX_WINDOW = 16,
  localparam int unsigned CW = $clog2(MAX_WINDOW + 1),
  localparam int unsigned SW = VALUE_BITS + CW,
  localparam int unsigned SNAP_W = 2 + CW + 4 * VALUE_BITS + 2 * INDEX_BITS + 2 * SW
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [SNAP_W-1:0] snap_i,
  input  wire logic              empty_i,
  output logic                   pop_o,
  iplr_out_if.source             out_o
);

  typedef struct packed {
    logic                  kind;
    logic [CW-1:0]         cnt;
    logic [VALUE_BITS-1:0] tu;
    logic [VALUE_BITS-1:0] tul;
    logic [INDEX_BITS-1:0] tuv;
    logic [VALUE_BITS-1:0] su;
    logic                  sv;
    logic [VALUE_BITS-1:0] tl;
    logic [INDEX_BITS-1:0] tmv;
    logic [SW-1:0]         sl;
    logic [SW-1:0]         sus;
  } snap_t;

  localparam int unsigned VB  = VALUE_BITS;
  localparam int unsigned DW  = VB + iplr_pkg::FracBits + 1;
  localparam int unsigned DCW = $clog2(DW + 1);
  localparam int unsigned MCW = $clog2(VB + 1);
  localparam int unsigned PW  = 2 * VB;
  localparam logic [VB-1:0] VMax = {1'b0, {(VB - 1){1'b1}}};
  localparam logic [VB-1:0] VMin = {1'b1, {(VB - 1){1'b0}}};
  localparam logic [VB-1:0] OneQ = VB'(1) << iplr_pkg::FracBits;

  iplr_pkg::back_state_e state_q, state_d;
  iplr_pkg::div_job_e    job_q, job_d;

  snap_t s_q, s;
  logic [DW-1:0]    dvd_q, dvd_d;
  logic [VB:0]      dvs_q, dvs_d;
  logic [VB+1:0]    rem_q, rem_d, rem_sh;
  logic [DCW-1:0]   dcnt_q, dcnt_d;
  logic [MCW-1:0]   mcnt_q, mcnt_d;
  logic signed [PW-1:0] acc_q, acc_d, fl;
  logic signed [PW:0]   diff;

  logic [VB-1:0] r_slope_q, r_slope_d, r_lb_q, r_lb_d, r_ub_q, r_ub_d;
  logic [VB-1:0] r_off_q, r_off_d;
  logic [INDEX_BITS-1:0] r_uv_q, r_uv_d, r_lv_q, r_lv_d;
  logic r_ex_q, r_ex_d, r_em_q, r_em_d;
  logic ovalid_q, ovalid_d;

  logic signed [VB:0] den_s;
  logic          exact, sec_ok, rnz;
  logic [DW:0]   q_up;
  logic [DW-1:0] q_neg_up, q_neg;
  logic [SW-1:0] mag_l, mag_u;
  logic [VB:0]   slope_num;

  assign s = s_q;
  assign den_s = $signed({s.tu[VB-1], s.tu}) - $signed({s.tul[VB-1], s.tul});
  assign sec_ok = !s.sv || ($signed(s.tl) >= $signed(s.su));
  assign exact = (sec_ok && ($signed(s.tul) >= $signed(s.tl))) || (den_s <= 0) || !s.sv;
  assign slope_num = {s.tu[VB-1], s.tu} - {s.su[VB-1], s.su};
  assign mag_l = s.sl[SW-1] ? (~s.sl + 1'b1) : s.sl;
  assign mag_u = s.sus[SW-1] ? (~s.sus + 1'b1) : s.sus;

  assign rem_sh   = {rem_q[VB:0], dvd_q[DW-1]};
  assign rnz      = (rem_q != '0);
  assign q_up     = {1'b0, dvd_q} + {{DW{1'b0}}, rnz};
  assign q_neg_up = ~q_up[DW-1:0] + 1'b1;
  assign q_neg    = ~dvd_q + 1'b1;

  assign fl   = acc_q >>> iplr_pkg::FracBits;
  assign diff = $signed({{(PW + 1 - VB){s.su[VB-1]}}, s.su}) - $signed({fl[PW-1], fl});

  assign pop_o = (state_q == iplr_pkg::ST_IDLE) && !empty_i;

  always_comb begin
    state_d  = state_q;
    job_d    = job_q;
    dvd_d    = dvd_q;
    dvs_d    = dvs_q;
    rem_d    = rem_q;
    dcnt_d   = dcnt_q;
    mcnt_d   = mcnt_q;
    acc_d    = acc_q;
    r_slope_d = r_slope_q;
    r_lb_d   = r_lb_q;
    r_ub_d   = r_ub_q;
    r_off_d  = r_off_q;
    r_uv_d   = r_uv_q;
    r_lv_d   = r_lv_q;
    r_ex_d   = r_ex_q;
    r_em_d   = r_em_q;
    ovalid_d = ovalid_q && !out_o.ready;
    case (state_q)
      iplr_pkg::ST_IDLE: begin
        if (!empty_i) state_d = iplr_pkg::ST_SETUP;
      end
      iplr_pkg::ST_SETUP: begin
        r_em_d = (s.cnt == '0);
        rem_d  = '0;
        dcnt_d = '0;
        state_d = iplr_pkg::ST_DIV;
        if (s.kind == iplr_pkg::PoolAvg) begin
          r_ex_d  = 1'b0;
          r_uv_d  = '0;
          r_lv_d  = '0;
          r_off_d = '0;
          job_d   = iplr_pkg::JOB_LOW;
          dvd_d   = DW'(mag_l);
          dvs_d   = (VB + 1)'(s.cnt);
        end else begin
          r_uv_d = s.tuv;
          r_lb_d = s.tl;
          r_ub_d = s.tu;
          if (exact) begin
            r_ex_d    = 1'b1;
            r_lv_d    = s.tuv;
            r_slope_d = OneQ;
            r_off_d   = '0;
            state_d   = iplr_pkg::ST_DONE;
          end else begin
            r_ex_d = 1'b0;
            r_lv_d = s.tmv;
            job_d  = iplr_pkg::JOB_SLOPE_MAX;
            dvd_d  = {slope_num, {iplr_pkg::FracBits{1'b0}}};
            dvs_d  = den_s[VB:0];
          end
        end
      end
      iplr_pkg::ST_DIV: begin
        // one quotient bit per cycle, restoring
        if (rem_sh >= {1'b0, dvs_q}) begin
          rem_d = rem_sh - {1'b0, dvs_q};
          dvd_d = {dvd_q[DW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          dvd_d = {dvd_q[DW-2:0], 1'b0};
        end
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == DCW'(DW)) begin
          // quotient and remainder are settled: finish the job
          rem_d  = '0;
          dcnt_d = '0;
          dvd_d  = dvd_q;
          state_d = iplr_pkg::ST_DIV;
          case (job_q)
            iplr_pkg::JOB_LOW: begin
              r_lb_d = s.sl[SW-1] ? q_neg_up[VB-1:0] : dvd_q[VB-1:0];
              job_d  = iplr_pkg::JOB_UPP;
              dvd_d  = DW'(mag_u);
            end
            iplr_pkg::JOB_UPP: begin
              r_ub_d = s.sus[SW-1] ? q_neg[VB-1:0] : q_up[VB-1:0];
              job_d  = iplr_pkg::JOB_SLOPE_AVG;
              dvd_d  = DW'(1) << iplr_pkg::FracBits;
            end
            iplr_pkg::JOB_SLOPE_AVG: begin
              r_slope_d = dvd_q[VB-1:0];
              state_d   = iplr_pkg::ST_DONE;
            end
            default: begin
              r_slope_d = (q_up > (DW + 1)'(VMax)) ? VMax : q_up[VB-1:0];
              acc_d     = '0;
              mcnt_d    = '0;
              state_d   = iplr_pkg::ST_MUL;
            end
          endcase
        end else begin
          state_d = iplr_pkg::ST_DIV;
        end
      end
      iplr_pkg::ST_MUL: begin
        if (mcnt_q == MCW'(VB)) begin
          if (diff > $signed({{(PW + 1 - VB){1'b0}}, VMax})) begin
            r_off_d = VMax;
          end else if (diff < $signed({{(PW + 1 - VB){1'b1}}, VMin})) begin
            r_off_d = VMin;
          end else begin
            r_off_d = diff[VB-1:0];
          end
          state_d = iplr_pkg::ST_DONE;
        end else begin
          // shift-add, slope bits from the top
          acc_d = (acc_q <<< 1) + (r_slope_q[VB - 1 - mcnt_q[MCW-1:0]] ?
                  $signed({{VB{s.tul[VB-1]}}, s.tul}) : $signed({PW{1'b0}}));
          mcnt_d = mcnt_q + 1'b1;
        end
      end
      iplr_pkg::ST_DONE: begin
        if (!ovalid_q || out_o.ready) begin
          ovalid_d = 1'b1;
          state_d  = iplr_pkg::ST_IDLE;
        end
      end
      default: state_d = iplr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= iplr_pkg::ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) s_q <= snap_i;
    job_q  <= job_d;
    dvd_q  <= dvd_d;
    dvs_q  <= dvs_d;
    rem_q  <= rem_d;
    dcnt_q <= dcnt_d;
    mcnt_q <= mcnt_d;
    acc_q  <= acc_d;
    r_slope_q <= r_slope_d;
    r_lb_q <= r_lb_d;
    r_ub_q <= r_ub_d;
    r_off_q <= r_off_d;
    r_uv_q <= r_uv_d;
    r_lv_q <= r_lv_d;
    r_ex_q <= r_ex_d;
    r_em_q <= r_em_d;
  end

  // result fields sit in a staging set; hold a copy for the output side
  logic [VB-1:0] o_slope_q, o_off_q, o_lb_q, o_ub_q;
  logic [INDEX_BITS-1:0] o_uv_q, o_lv_q;
  logic o_ex_q, o_em_q;
  logic load;

  assign load = (state_q == iplr_pkg::ST_DONE) && (!ovalid_q || out_o.ready);

  always_ff @(posedge clk_i) begin
    if (load) begin
      o_slope_q <= r_slope_q;
      o_off_q   <= r_off_q;
      o_lb_q    <= r_lb_q;
      o_ub_q    <= r_ub_q;
      o_uv_q    <= r_uv_q;
      o_lv_q    <= r_lv_q;
      o_ex_q    <= r_ex_q;
      o_em_q    <= r_em_q;
    end
  end

  assign out_o.valid        = ovalid_q;
  assign out_o.exact_copy   = o_ex_q;
  assign out_o.upper_var    = o_uv_q;
  assign out_o.lower_var    = o_lv_q;
  assign out_o.slope        = o_slope_q;
  assign out_o.offset       = o_off_q;
  assign out_o.lower_bound  = o_lb_q;
  assign out_o.upper_bound  = o_ub_q;
  assign out_o.empty_window = o_em_q;

endmodule
`default_nettype wire

>>> hdl/interval_pool_bound_relaxation_core.sv
// Top level of the interval pool bound relaxation block: config register,
// front end, snapshot queue, back end. Uses iplr_pkg and the iplr_*_if files.
//
//   channel  dir  modport  carries
//   in_i     in   sink     lower, upper, var_index, last
//   out_o    out  source   exact_copy, vars, slope, offset, bounds, empty_window
//   cfg_i    in   sink     pool_kind (data)
//
// One element is taken each cycle while the two-entry snapshot queue has room.
// Per window the back end runs setup; in max mode an exact window goes straight
// to output, a sloped one runs the divider and then the multiplier; average mode
// runs three divider passes (lower bound, upper bound, slope), then outputs.
// Reset clears the window and queue counters and the output valid. A stalled
// output holds its item; the front takes elements while the queue has room.
`default_nettype none
module interval_pool_bound_relaxation_core #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned INDEX_BITS = 20,
  parameter int unsigned MAX_WINDOW = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  iplr_in_if.sink   in_i,
  iplr_out_if.source out_o,
  iplr_cfg_if.sink  cfg_i
);

  localparam int unsigned CW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SW = VALUE_BITS + CW;
  localparam int unsigned SNAP_W = 2 + CW + 4 * VALUE_BITS + 2 * INDEX_BITS + 2 * SW;

  logic              pool_kind_q;
  logic              push, pop, q_full, q_empty;
  logic [SNAP_W-1:0] snap_in, snap_out;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_kind_q <= iplr_pkg::PoolMax;
    end else if (cfg_i.valid) begin
      pool_kind_q <= cfg_i.data;
    end
  end

  iplr_front #(
    .VALUE_BITS(VALUE_BITS), .INDEX_BITS(INDEX_BITS), .MAX_WINDOW(MAX_WINDOW)
  ) u_front (
    .clk_i, .rst_ni, .in_i,
    .pool_kind_i(pool_kind_q), .full_i(q_full), .push_o(push), .snap_o(snap_in)
  );

  iplr_queue #(.WIDTH(SNAP_W)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(snap_in), .pop_i(pop),
    .data_o(snap_out), .full_o(q_full), .empty_o(q_empty)
  );

  iplr_back #(
    .VALUE_BITS(VALUE_BITS), .INDEX_BITS(INDEX_BITS), .MAX_WINDOW(MAX_WINDOW)
  ) u_back (
    .clk_i, .rst_ni, .snap_i(snap_out), .empty_i(q_empty), .pop_o(pop), .out_o
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full) else $error("snapshot pushed into a full queue");
  a_never_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !out_o.empty_window) else $error("empty window reported");
  a_exact_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.exact_copy) |-> (out_o.offset == '0))
    else $error("exact result with nonzero offset");
`endif

endmodule
`default_nettype wire
